### rtl/core/ded_pkg.sv
`default_nettype none

package ded_pkg;

    // accumulator and result geometry
    localparam int ACC_W       = 41;
    localparam int MAG_W       = 22;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DIST_W      = 21;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

    // difference magnitude cap and accumulator ceiling
    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // digit-by-digit square root, two radicand bits per step
    localparam int SQRT_STEPS = DIST_W;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int REM_W      = DIST_W + 4;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one finished descriptor waiting for its square root
    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             ovf;
    } job_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // square root sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } sqrt_state_t;

endpackage

`default_nettype wire

### rtl/core/ded_front.sv
`default_nettype none

module ded_front
    import ded_pkg::*;
#(
    parameter int MAX_ELEMENTS = 512,
    parameter int ELEM_WIDTH   = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ELEM_WIDTH-1:0] elem_a,
    input  wire logic [ELEM_WIDTH-1:0] elem_b,
    input  wire logic                  last_pair,
    input  wire q_stat_t               q_stat,
    output logic                       push,
    output job_t                       push_job
);

    localparam int MW    = ELEM_WIDTH + 1;
    localparam int XW    = (MW > MAG_W) ? MW : MAG_W;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic             p1_valid_reg, p2_valid_reg;
    logic             p1_last_reg, p2_last_reg;
    logic [MAG_W-1:0] p1_mag_reg;
    logic [SQ_W-1:0]  p2_sq_reg;
    logic [ACC_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;

    logic             advance;
    logic [MW-1:0]    diff_c, abs_c;
    logic [XW-1:0]    abs_x;
    logic [MAG_W-1:0] mag_c;
    logic [SQ_W-1:0]  sq_c;
    logic [SQ_W:0]    sum_wide;
    logic             sat, cnt_full;
    logic [ACC_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_next;
    logic             ovf_next;

    // whole pipe holds while a finished descriptor cannot enter the queue
    assign advance  = !(p2_valid_reg && p2_last_reg && q_stat.full);
    assign in_ready = advance;

    // sign-extended difference, magnitude, cap
    assign diff_c = {elem_a[ELEM_WIDTH-1], elem_a} - {elem_b[ELEM_WIDTH-1], elem_b};
    assign abs_c  = diff_c[MW-1] ? (~diff_c + MW'(1)) : diff_c;
    assign abs_x  = XW'(abs_c);
    assign mag_c  = (abs_x > XW'(MAG_CAP)) ? MAG_CAP : MAG_W'(abs_x);

    // square of the capped magnitude
    assign sq_c = p1_mag_reg * p1_mag_reg;

    // saturating accumulate and pair count
    always_comb begin
        sum_wide = (SQ_W + 1)'(sum_reg) + (SQ_W + 1)'(p2_sq_reg);
        sat      = sum_wide > (SQ_W + 1)'(ACC_MAX);
        sum_next = sat ? ACC_MAX : sum_wide[ACC_W-1:0];
        cnt_full = cnt_reg >= CNT_W'(MAX_ELEMENTS);
        cnt_next = cnt_full ? cnt_reg : cnt_reg + CNT_W'(1);
        ovf_next = ovf_reg | sat | cnt_full;
    end

    assign push         = advance && p2_valid_reg && p2_last_reg;
    assign push_job.sum = sum_next;
    assign push_job.ovf = ovf_next;

    // stage valids and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg) begin
                if (p2_last_reg) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_mag_reg  <= mag_c;
            p1_last_reg <= last_pair;
            p2_sq_reg   <= sq_c;
            p2_last_reg <= p1_last_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("pair count passed its limit");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

### rtl/core/ded_queue.sv
`default_nettype none

module ded_queue
    import ded_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output q_stat_t   q_stat
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign q_stat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/core/ded_sqrt.sv
`default_nettype none

module ded_sqrt
    import ded_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire q_stat_t                 q_stat,
    input  wire job_t                    pop_job,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [DIST_W-1:0]            out_dist,
    output logic                         out_ovf
);

    sqrt_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic              job_ovf_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              ovf_reg;

    logic              load_out;
    logic              last_step;
    logic [REM_W-1:0]  rem_shift, trial;
    logic              ge;

    assign last_step = step_reg == STEP_W'(SQRT_STEPS - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop      = !q_stat.empty;
            ST_RUN:  pop      = 1'b0;
            ST_HOLD: load_out = !out_valid_reg || out_ready;
            default: pop      = 1'b0;
        endcase
    end

    // one root bit per step
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign ge        = rem_shift >= trial;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            rad_reg     <= RAD_W'(pop_job.sum);
            rem_reg     <= '0;
            root_reg    <= '0;
            step_reg    <= '0;
            job_ovf_reg <= pop_job.ovf;
        end else if (state_reg == ST_RUN) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[DIST_W-2:0], ge};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (load_out) begin
            dist_reg <= root_reg;
            ovf_reg  <= job_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_dist  = dist_reg;
    assign out_ovf   = ovf_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> step_reg < STEP_W'(SQRT_STEPS))
        else $error("square root ran past its last step");

    a_load_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_HOLD) |-> $past(state_reg == ST_RUN) && $past(last_step))
        else $error("result stage entered without a finished root");

endmodule

`default_nettype wire

### rtl/core/descriptor_euclidean_distance_core.sv
`default_nettype none

// channel   dir  tdata (low bit up)                 tuser     tlast
// s_axis    in   elem_a, elem_b (signed, ELEM_WIDTH) -         last_pair
// m_axis    out  distance[20:0], zero pad to 24      overflow  -
//
// one element pair is accepted every cycle while the queue has room
// a result leaves through p1, p2, the queue, the root steps and the result register;
// the square root unit works on one descriptor at a time, so short ones wait on it
// synchronous active-low reset clears pipe valids, accumulator, queue, sequencer
// a stall on m_axis backs up the queue and then s_axis_tready drops

module descriptor_euclidean_distance_core
    import ded_pkg::*;
#(
    parameter int MAX_ELEMENTS = 512,
    parameter int ELEM_WIDTH   = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // elem_a, elem_b
    input  wire logic [((2*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // distance
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // overflow
    output logic                        m_axis_tuser
);

    q_stat_t           q_stat;
    logic              push, pop;
    job_t              push_job, pop_job;
    logic [DIST_W-1:0] distance;

    // accumulate front
    ded_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .ELEM_WIDTH  (ELEM_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .elem_a   (s_axis_tdata[ELEM_WIDTH-1:0]),
        .elem_b   (s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
        .last_pair(s_axis_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // finished sums awaiting the root
    ded_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .pop_job (pop_job),
        .q_stat  (q_stat)
    );

    // square root back end and result register
    ded_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_dist (distance),
        .out_ovf  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'(distance);

endmodule

`default_nettype wire
